@@ rtl/dmnc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmnc_pkg: shared types and constants of the MESI node controller
// Message codes, line and directory states, and the result record.
// ----------------------------------------------------------------------------
package dmnc_pkg;

    localparam int Nodes      = 4;
    localparam int MemBlocks  = 16;
    localparam int CacheLines = 4;
    localparam int NodeId     = 0;
    localparam int MaxRes     = 4;
    localparam int LineW      = (CacheLines > 1) ? $clog2(CacheLines) : 1;
    localparam int MemW       = (MemBlocks > 1) ? $clog2(MemBlocks) : 1;
    localparam int ResW       = $clog2(MaxRes + 1);

    typedef enum logic [3:0] {
        CMD_LOCAL_RD  = 4'd0,
        CMD_LOCAL_WR  = 4'd1,
        CMD_RD_REQ    = 4'd2,
        CMD_WR_REQ    = 4'd3,
        CMD_REPLY_RD  = 4'd4,
        CMD_REPLY_WR  = 4'd5,
        CMD_REPLY_ID  = 4'd6,
        CMD_INV       = 4'd7,
        CMD_UPGRADE   = 4'd8,
        CMD_WB_INV    = 4'd9,
        CMD_WB_INT    = 4'd10,
        CMD_FLUSH     = 4'd11,
        CMD_FLUSH_IA  = 4'd12,
        CMD_EVICT_SH  = 4'd13,
        CMD_EVICT_MOD = 4'd14,
        CMD_NONE      = 4'd15
    } cmd_t;

    typedef enum logic [3:0] {
        MSG_RD_REQ    = 4'd0,
        MSG_WR_REQ    = 4'd1,
        MSG_REPLY_RD  = 4'd2,
        MSG_REPLY_WR  = 4'd3,
        MSG_REPLY_ID  = 4'd4,
        MSG_INV       = 4'd5,
        MSG_UPGRADE   = 4'd6,
        MSG_WB_INV    = 4'd7,
        MSG_WB_INT    = 4'd8,
        MSG_FLUSH     = 4'd9,
        MSG_FLUSH_IA  = 4'd10,
        MSG_EVICT_SH  = 4'd11,
        MSG_EVICT_MOD = 4'd12
    } msg_t;

    localparam logic [1:0] ST_M = 2'd0;
    localparam logic [1:0] ST_E = 2'd1;
    localparam logic [1:0] ST_S = 2'd2;
    localparam logic [1:0] ST_I = 2'd3;
    localparam logic [1:0] D_EM = 2'd0;
    localparam logic [1:0] D_S  = 2'd1;
    localparam logic [1:0] D_U  = 2'd2;

    typedef struct packed {
        logic [3:0] command;
        logic [1:0] sender;
        logic [7:0] address;
        logic [7:0] value;
        logic [3:0] sharers;
        logic [1:0] second_receiver;
    } in_item_t;

    typedef struct packed {
        logic [3:0] msg_kind;
        logic [1:0] dest;
        logic [7:0] out_address;
        logic [7:0] out_value;
        logic [3:0] out_sharers;
        logic [1:0] out_requester;
        logic       last_of_run;
    } out_item_t;

    typedef out_item_t [MaxRes-1:0] res_list_t;

endpackage
`default_nettype wire

@@ rtl/dmnc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmnc_in_if / dmnc_out_if: valid/ready channels of the node controller
// One transfer at each edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface dmnc_in_if;
    logic                      valid;
    logic                      ready;
    dmnc_pkg::in_item_t        data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dmnc_out_if;
    logic                      valid;
    logic                      ready;
    dmnc_pkg::out_item_t       data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/dmnc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmnc_core: state update of the node controller
// Applies one item to cache, directory and memory and builds its results.
// ----------------------------------------------------------------------------
module dmnc_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  dmnc_pkg::in_item_t        item,
    output dmnc_pkg::res_list_t       res,
    output logic [dmnc_pkg::ResW-1:0] res_count
);
    import dmnc_pkg::*;

    logic [7:0] line_tag_reg [CacheLines];
    logic [7:0] line_data_reg [CacheLines];
    logic [1:0] line_status_reg [CacheLines];
    logic [7:0] block_data_reg [MemBlocks];
    logic [1:0] dir_status_reg [MemBlocks];
    logic [3:0] dir_holders_reg [MemBlocks];
    logic       awaiting_reply_reg;
    logic [7:0] pend_addr_reg;
    logic [7:0] pend_value_reg;

    logic [7:0] tag_next, ldata_next, bdata_next, paddr_next, pval_next;
    logic [1:0] lstat_next, dstat_next;
    logic [3:0] dhold_next;
    logic       await_next;
    logic [LineW-1:0] li;
    logic [MemW-1:0]  mi;
    logic [3:0] home, sbit, h, hrest;
    logic [7:0] addr, otag, oldd;
    logic [1:0] ost, ds;
    logic       hit, is_home;
    logic [2:0] cnt;
    logic [1:0] own, lastn;
    out_item_t  evict_msg;
    logic       evict_v;
    logic [ResW-1:0] n;

    function automatic out_item_t mk(logic [3:0] k, logic [3:0] d, logic [7:0] a,
                                     logic [7:0] v, logic [3:0] s, logic [1:0] r);
        out_item_t o;
        o.msg_kind = k;
        o.dest = d[1:0];
        o.out_address = a;
        o.out_value = v;
        o.out_sharers = s;
        o.out_requester = r;
        o.last_of_run = 1'b0;
        return o;
    endfunction

    always_comb
    begin
        addr = item.address;
        home = addr[7:4];
        li = LineW'(addr[3:0] % CacheLines);
        mi = MemW'(addr[3:0] % MemBlocks);
        sbit = 4'(1) << item.sender;
        otag = line_tag_reg[li];
        oldd = line_data_reg[li];
        ost = line_status_reg[li];
        hit = (otag == addr) && (ost != ST_I);
        is_home = (home == 4'(NodeId));
        h = dir_holders_reg[mi];
        hrest = h & ~sbit;
        ds = dir_status_reg[mi];
        if (ds == 2'd3 || ((item.command == CMD_RD_REQ || item.command == CMD_WR_REQ)
                           && ds == D_EM && h == 4'd0))
        begin
            ds = D_U;
        end
        own = h[0] ? 2'd0 : h[1] ? 2'd1 : h[2] ? 2'd2 : 2'd3;
        cnt = 3'(hrest[0]) + 3'(hrest[1]) + 3'(hrest[2]) + 3'(hrest[3]);
        lastn = hrest[3] ? 2'd3 : hrest[2] ? 2'd2 : hrest[1] ? 2'd1 : 2'd0;
        evict_v = (ost != ST_I) && (otag != addr);
        evict_msg = (ost == ST_M) ? mk(MSG_EVICT_MOD, otag[7:4], otag, oldd, 4'd0, 2'd0)
                                  : mk(MSG_EVICT_SH, otag[7:4], otag, 8'd0, 4'd0, 2'd0);
        tag_next = otag;
        ldata_next = oldd;
        lstat_next = ost;
        bdata_next = block_data_reg[mi];
        dstat_next = dir_status_reg[mi];
        dhold_next = h;
        await_next = awaiting_reply_reg;
        paddr_next = pend_addr_reg;
        pval_next = pend_value_reg;
        res = '0;
        n = '0;
        unique case (item.command)
            CMD_LOCAL_RD:
            begin
                if (!hit)
                begin
                    res[0] = mk(MSG_RD_REQ, home, addr, 8'd0, 4'd0, 2'd0);
                    n = ResW'(1);
                    await_next = 1'b1;
                end
            end
            CMD_LOCAL_WR:
            begin
                paddr_next = addr;
                pval_next = item.value;
                if (hit && ost != ST_S)
                begin
                    ldata_next = item.value;
                    lstat_next = ST_M;
                end
                else
                begin
                    res[0] = mk(hit ? MSG_UPGRADE : MSG_WR_REQ, home, addr, item.value,
                                4'd0, 2'd0);
                    n = ResW'(1);
                    await_next = 1'b1;
                end
            end
            CMD_RD_REQ, CMD_WR_REQ:
            begin
                n = ResW'(1);
                if (ds == D_EM)
                begin
                    res[0] = mk((item.command == CMD_RD_REQ) ? MSG_WB_INT : MSG_WB_INV,
                                {2'd0, own}, addr, 8'd0, 4'd0, item.sender);
                end
                else if (item.command == CMD_RD_REQ)
                begin
                    dhold_next = h | sbit;
                    dstat_next = D_S;
                    res[0] = mk(MSG_REPLY_RD, {2'd0, item.sender}, addr,
                                block_data_reg[mi], 4'd0, 2'd0);
                end
                else
                begin
                    res[0] = (ds == D_S)
                        ? mk(MSG_REPLY_ID, {2'd0, item.sender}, addr, block_data_reg[mi],
                             hrest, 2'd0)
                        : mk(MSG_REPLY_WR, {2'd0, item.sender}, addr, block_data_reg[mi],
                             4'd0, 2'd0);
                    dstat_next = D_EM;
                    dhold_next = sbit;
                end
            end
            CMD_REPLY_RD, CMD_REPLY_WR, CMD_FLUSH, CMD_FLUSH_IA:
            begin
                if (is_home && item.command == CMD_FLUSH)
                begin
                    bdata_next = item.value;
                    dstat_next = D_S;
                    dhold_next = h | sbit;
                end
                else if (is_home && item.command == CMD_FLUSH_IA)
                begin
                    bdata_next = item.value;
                end
                else
                begin
                    if (evict_v)
                    begin
                        res[0] = evict_msg;
                        n = ResW'(1);
                    end
                    tag_next = addr;
                    if (item.command == CMD_REPLY_WR || item.command == CMD_FLUSH_IA)
                    begin
                        ldata_next = (pend_addr_reg == addr) ? pend_value_reg : item.value;
                        lstat_next = ST_M;
                    end
                    else
                    begin
                        ldata_next = item.value;
                        lstat_next = ST_S;
                    end
                    await_next = 1'b0;
                end
            end
            CMD_REPLY_ID:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (i < Nodes && item.sharers[i] && i != NodeId)
                    begin
                        res[n[1:0]] = mk(MSG_INV, 4'(i), addr, 8'd0, 4'd0, 2'd0);
                        n = n + ResW'(1);
                    end
                end
                ldata_next = oldd;
                if (otag != addr || ost == ST_I)
                begin
                    if (evict_v)
                    begin
                        if (n < ResW'(MaxRes))
                        begin
                            res[n[1:0]] = evict_msg;
                            n = n + ResW'(1);
                        end
                    end
                    tag_next = addr;
                    ldata_next = item.value;
                end
                if (pend_addr_reg == addr)
                begin
                    ldata_next = pend_value_reg;
                end
                lstat_next = ST_M;
                await_next = 1'b0;
            end
            CMD_INV:
            begin
                if (hit)
                begin
                    lstat_next = ST_I;
                end
            end
            CMD_UPGRADE:
            begin
                res[0] = mk(MSG_REPLY_ID, {2'd0, item.sender}, addr, 8'd0, hrest, 2'd0);
                n = ResW'(1);
                dstat_next = D_EM;
                dhold_next = sbit;
            end
            CMD_WB_INV, CMD_WB_INT:
            begin
                if (otag == addr && (ost == ST_M || ost == ST_E))
                begin
                    res[0] = mk((item.command == CMD_WB_INV) ? MSG_FLUSH_IA : MSG_FLUSH,
                                home, addr, oldd, 4'd0, 2'd0);
                    res[1] = mk((item.command == CMD_WB_INV) ? MSG_FLUSH_IA : MSG_FLUSH,
                                {2'd0, item.second_receiver}, addr, oldd, 4'd0, 2'd0);
                    n = ({2'd0, item.second_receiver} != home) ? ResW'(2) : ResW'(1);
                    lstat_next = (item.command == CMD_WB_INV) ? ST_I : ST_S;
                end
            end
            CMD_EVICT_SH:
            begin
                if (is_home)
                begin
                    dhold_next = hrest;
                    if (cnt == 3'd0)
                    begin
                        dstat_next = D_U;
                    end
                    else if (cnt == 3'd1)
                    begin
                        dstat_next = D_EM;
                        res[0] = mk(MSG_EVICT_SH, {2'd0, lastn}, addr, 8'd0, 4'd0, 2'd0);
                        n = ResW'(1);
                    end
                end
                else if (otag == addr && ost == ST_S)
                begin
                    lstat_next = ST_E;
                end
            end
            CMD_EVICT_MOD:
            begin
                if (is_home)
                begin
                    bdata_next = item.value;
                    dstat_next = D_U;
                    dhold_next = hrest;
                end
            end
            default:
            begin
            end
        endcase
        if (n != '0)
        begin
            res[2'(n - ResW'(1))].last_of_run = 1'b1;
        end
        res_count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CacheLines; i++)
            begin
                line_tag_reg[i] <= 8'hFF;
                line_data_reg[i] <= 8'd0;
                line_status_reg[i] <= ST_I;
            end
            for (int i = 0; i < MemBlocks; i++)
            begin
                block_data_reg[i] <= 8'(20 * NodeId + i);
                dir_status_reg[i] <= D_U;
                dir_holders_reg[i] <= 4'd0;
            end
            awaiting_reply_reg <= 1'b0;
            pend_addr_reg <= 8'd0;
            pend_value_reg <= 8'd0;
        end
        else if (step)
        begin
            line_tag_reg[li] <= tag_next;
            line_data_reg[li] <= ldata_next;
            line_status_reg[li] <= lstat_next;
            block_data_reg[mi] <= bdata_next;
            dir_status_reg[mi] <= dstat_next;
            dir_holders_reg[mi] <= dhold_next;
            awaiting_reply_reg <= await_next;
            pend_addr_reg <= paddr_next;
            pend_value_reg <= pval_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/directory_mesi_node_controller_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// directory_mesi_node_controller_top: one node of a directory MESI system
// Registers an input item, applies it and streams its outgoing messages.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_ch     in   command sender address value sharers second_receiver
// out_ch    out  msg_kind dest out_address out_value out_sharers out_requester
//                last_of_run
// An accepted item is registered, applied to state once the buffer can take its
// 0..4 results, which are then sent one per cycle while out_ch is ready.
// The next item is taken once the buffer is empty or its last message is taken.
// Reset restores cache, directory and memory at once.
// ----------------------------------------------------------------------------
module directory_mesi_node_controller_top (
    input wire logic  clk,
    input wire logic  rst_n,
    dmnc_in_if.sink   in_ch,
    dmnc_out_if.source out_ch
);
    import dmnc_pkg::*;

    in_item_t        item_reg;
    logic            item_v_reg;
    res_list_t       buf_reg;
    logic [ResW-1:0] cnt_reg;
    logic [ResW-1:0] idx_reg;
    res_list_t       res;
    logic [ResW-1:0] res_count;
    logic            buf_busy, buf_last, step;

    dmnc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item_reg),
        .res       (res),
        .res_count (res_count)
    );

    assign buf_busy = (idx_reg != cnt_reg);
    assign buf_last = out_ch.ready && (idx_reg + ResW'(1) == cnt_reg);
    assign step = item_v_reg && (!buf_busy || buf_last);
    assign in_ch.ready = !item_v_reg || step;
    assign out_ch.valid = buf_busy;
    assign out_ch.data = buf_reg[idx_reg[1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_v_reg <= 1'b0;
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                item_v_reg <= in_ch.valid;
            end
            if (step)
            begin
                cnt_reg <= res_count;
                idx_reg <= '0;
            end
            else if (buf_busy && out_ch.ready)
            begin
                idx_reg <= idx_reg + ResW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            item_reg <= in_ch.data;
        end
        if (step)
        begin
            buf_reg <= res;
        end
    end

endmodule
`default_nettype wire

@@ rtl/dmnc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmnc_checker: port-level checks of the node controller
// Watches the handshakes and message fields at the top-level ports.
// ----------------------------------------------------------------------------
module dmnc_checker (
    input wire logic   clk,
    input wire logic   rst_n,
    dmnc_in_if.sink    in_ch,
    dmnc_out_if.source out_ch
);
    import dmnc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("stalled transfer changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.data.msg_kind <= MSG_EVICT_MOD)
        else $error("bad message kind");

    a_inv_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.msg_kind == MSG_INV |->
        out_ch.data.out_value == 8'd0 && out_ch.data.out_sharers == 4'd0)
        else $error("inv carries payload");

    a_req_only_wb: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.out_requester != 2'd0 |->
        (out_ch.data.msg_kind == MSG_WB_INV || out_ch.data.msg_kind == MSG_WB_INT))
        else $error("requester on wrong message");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input blocked with no result pending");

endmodule

bind directory_mesi_node_controller_top dmnc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
`default_nettype wire
